/* rtl/bia_pkg.sv */
// Shared types, constants and helpers for the bitmap identifier allocator.
`timescale 1ns / 1ps

package bia_pkg;

    localparam int MAX_ID    = 65535;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAX_ID + WORD_BITS) / WORD_BITS;
    localparam int IO_W      = 16;

    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int ADDR_W   = $clog2(MAP_WORDS);
    localparam int CNT_W    = $clog2(MAP_WORDS + 1);
    localparam int ID_RAW_W = $clog2(MAX_ID + 1);
    localparam int ID_W     = (ID_RAW_W > IO_W) ? ID_RAW_W : IO_W;
    localparam int HINT_W   = ID_W + 1;
    localparam int LAST_BIT = MAX_ID % WORD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BIT_W-1:0]     bit_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ID_W-1:0]      id_t;
    typedef logic [HINT_W-1:0]    hint_t;

    localparam addr_t LAST_ADDR = addr_t'(MAP_WORDS - 1);
    // bits of the last map word that lie above the maximum identifier
    localparam word_t TOP_MASK  = ~((word_t'(2) << LAST_BIT) - word_t'(1));

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic ign;
        logic chk;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic ign;
        logic chk_done;
        logic out_free;
    } ctrl_sts_t;

    function automatic bit_t first_one(input word_t v);
        bit_t idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = bit_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/bia_ctrl.sv */
// Controller state machine for the bitmap identifier allocator.
`timescale 1ns / 1ps

module bia_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bia_pkg::ctrl_sts_t  sts,
    output bia_pkg::ctrl_cmd_t  cmd
);
    import bia_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (sts.ign) begin
                    cmd.ign    = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.chk = 1'b1;
                if (sts.chk_done) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_READ;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bia_datapath.sv */
// Datapath: used-bit map memory, search hint, word scan and result register.
`timescale 1ns / 1ps

module bia_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_action,
    input  logic [bia_pkg::IO_W-1:0]  s_id_in,
    input  bia_pkg::ctrl_cmd_t        cmd,
    output bia_pkg::ctrl_sts_t        sts,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [bia_pkg::IO_W-1:0]  m_id_out,
    output logic [1:0]                m_status
);
    import bia_pkg::*;

    word_t            mem [MAP_WORDS];
    word_t            rdata_reg;
    logic             op_reg;
    logic [IO_W-1:0]  req_reg;
    hint_t            hint_reg;
    addr_t            addr_reg;
    bit_t             bit_reg;
    logic             first_reg;
    cnt_t             cnt_reg;
    logic [IO_W-1:0]  res_id_reg;
    status_t          res_st_reg;
    logic             m_valid_reg;
    logic [IO_W-1:0]  m_id_out_reg;
    status_t          m_status_reg;

    word_t  bit_onehot;
    word_t  low_mask;
    word_t  top_mask;
    word_t  free_vec;
    logic   hit;
    bit_t   found_bit;
    word_t  found_onehot;
    id_t    found_id;
    logic   scan_last;
    logic   req_ok;
    logic   hint_ok;
    id_t    start_id;
    id_t    req_id;
    logic   op_free;
    logic   mem_we;
    word_t  mem_wdata;

    assign op_free      = (op_reg == ACT_FREE);
    assign bit_onehot   = word_t'(1) << bit_reg;
    assign low_mask     = first_reg ? (bit_onehot - word_t'(1)) : '0;
    assign top_mask     = (addr_reg == LAST_ADDR) ? TOP_MASK : '0;
    assign free_vec     = ~(rdata_reg | low_mask | top_mask);
    assign hit          = |free_vec;
    assign found_bit    = first_one(free_vec);
    assign found_onehot = word_t'(1) << found_bit;
    assign found_id     = id_t'({addr_reg, found_bit});
    assign scan_last    = (cnt_reg == cnt_t'(MAP_WORDS));
    assign req_ok       = (req_reg != '0) && (32'(req_reg) <= 32'(MAX_ID));
    assign hint_ok      = (hint_reg != '0) && (hint_reg <= hint_t'(MAX_ID));
    assign start_id     = hint_ok ? id_t'(hint_reg) : id_t'(1);
    assign req_id       = id_t'(s_id_in);

    assign mem_we = cmd.clr || (cmd.chk && (op_free || hit));

    always_comb begin
        if (cmd.clr) begin
            mem_wdata = (addr_reg == '0) ? word_t'(1) : '0;
        end else if (op_free) begin
            mem_wdata = rdata_reg & ~bit_onehot;
        end else begin
            mem_wdata = rdata_reg | found_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            hint_reg    <= hint_t'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                addr_reg <= addr_reg + addr_t'(1);
            end
            if (cmd.load) begin
                op_reg    <= s_action;
                req_reg   <= s_id_in;
                first_reg <= 1'b1;
                cnt_reg   <= '0;
                if (s_action == ACT_FREE) begin
                    addr_reg <= addr_t'(req_id >> BIT_W);
                    bit_reg  <= req_id[BIT_W-1:0];
                end else begin
                    addr_reg <= addr_t'(start_id >> BIT_W);
                    bit_reg  <= start_id[BIT_W-1:0];
                end
            end
            if (cmd.ign) begin
                res_id_reg <= '0;
                res_st_reg <= ST_IGNORED;
            end
            if (cmd.chk) begin
                if (op_free) begin
                    if (hint_t'(req_reg) < hint_reg) begin
                        hint_reg <= hint_t'(req_reg);
                    end
                    res_id_reg <= req_reg;
                    res_st_reg <= ST_FREED;
                end else if (hit) begin
                    hint_reg   <= hint_t'(found_id) + hint_t'(1);
                    res_id_reg <= found_id[IO_W-1:0];
                    res_st_reg <= ST_ALLOCATED;
                end else if (scan_last) begin
                    res_id_reg <= '0;
                    res_st_reg <= ST_FULL;
                end else begin
                    addr_reg  <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + addr_t'(1);
                    cnt_reg   <= cnt_reg + cnt_t'(1);
                    first_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg  <= 1'b1;
                m_id_out_reg <= res_id_reg;
                m_status_reg <= res_st_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last = (addr_reg == LAST_ADDR);
    assign sts.ign      = op_free && !req_ok;
    assign sts.chk_done = op_free || hit || scan_last;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_id_out = m_id_out_reg;
    assign m_status = m_status_reg;

endmodule

/* rtl/bitmap_id_allocator_core.sv */
// Usage: next-fit identifier allocator over a used-bit map, one request at a time.
// Input channel (s_valid/s_ready): s_action 0 allocates an identifier,
//   s_action 1 frees s_id_in. One transfer carries one request.
// Result channel (m_valid/m_ready): one transfer per request with m_id_out
//   (allocated or freed identifier, 0 when none) and m_status
//   (0 allocated, 1 map full, 2 freed, 3 free out of range ignored).
// Sequence: a free, or an allocate that finds a free bit in the hint's map word,
//   passes S_READ (memory read), S_CHECK and S_OUT, which loads the result and
//   sets m_valid once the output register is free; an ignored free skips S_CHECK.
//   Each further word adds a read and a check; a full map scans all 1024 words
//   and the hint's word again. The single-port 1024 x 64 map memory sets the pace.
// Flow: one request in flight; s_ready is high only while idle, so the next
//   request is taken only once the previous one has left S_OUT. A result waiting
//   in the output register does not block the next request's transfer or its
//   scan, only the loading of its own result.
// Reset: aresetn is synchronous, active low. After release the map is cleared
//   one word per cycle (all 1024 words, identifier 0 marked used) with s_ready low.
// Stall: a low m_ready holds the result steady; the controller waits with the
//   next result until the output register is free.
`timescale 1ns / 1ps

module bitmap_id_allocator_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [bia_pkg::IO_W-1:0]  s_id_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bia_pkg::IO_W-1:0]  m_id_out,
    output logic [1:0]                m_status
);
    import bia_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    bia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bia_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_action (s_action),
        .s_id_in  (s_id_in),
        .cmd      (cmd),
        .sts      (sts),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_id_out (m_id_out),
        .m_status (m_status)
    );

endmodule
